// File: rtl/core/iset_pkg.sv
// Shared types, constants and bit-scan functions for the integer set core.
package iset_pkg;

    localparam int KEY_W = 12;
    localparam int MODE_W = 3;
    localparam int KEY_BITS = 12;
    localparam int LEAF_BITS = 6;
    localparam int LEAF_W = 1 << LEAF_BITS;
    localparam int IDX_BITS = KEY_BITS - LEAF_BITS;
    localparam int NUM_LEAVES = 1 << IDX_BITS;

    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PREV   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0] value;
        logic             found;
        logic             set_empty;
    } rsp_t;

    // Position of the lowest set bit; zero for an all-zero word.
    function automatic logic [LEAF_BITS-1:0] low_index(logic [LEAF_W-1:0] w);
        logic [LEAF_W-1:0]    iso;
        logic [LEAF_BITS-1:0] idx;
        iso = w & (~w + LEAF_W'(1));
        idx = '0;
        for (int i = 0; i < LEAF_W; i++)
        begin
            if (iso[i])
            begin
                idx = idx | LEAF_BITS'(i);
            end
        end
        return idx;
    endfunction

    // Position of the highest set bit, found by scanning the mirrored word.
    function automatic logic [LEAF_BITS-1:0] high_index(logic [LEAF_W-1:0] w);
        logic [LEAF_W-1:0] rev;
        for (int i = 0; i < LEAF_W; i++)
        begin
            rev[i] = w[LEAF_W-1-i];
        end
        return LEAF_BITS'(LEAF_W - 1) - low_index(rev);
    endfunction

endpackage

// File: rtl/core/integer_set_successor_predecessor_core.sv
// Top level of the integer set core: request sequencer, summary word and result register.
//
// The core keeps a set of keys over 2^KEY_BITS values as 64-bit leaf words in a
// synchronous memory plus a summary register with one bit per non-empty leaf. Each
// request gives exactly one response. The leaf read is issued in the cycle of the
// request transfer; the leaf state updates or searches the word and the done state
// loads the output register, and only then is a new request transferred. A
// successor or predecessor search that finds nothing in its own leaf but finds a
// non-empty leaf in the summary scan passes through a further state, because a
// second leaf read is issued once the summary scan has picked the leaf. A stalled
// response holds the next result in the done state for as long as it waits. One
// request is worked on at a time; the next may be transferred while a response
// waits in the output register. A leaf whose summary bit is clear reads as zero,
// so reset and clear take effect at once, with no sweep over the memory.
module integer_set_successor_predecessor_core
    import iset_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LEAF  = 4'b0010,
        ST_SCAN2 = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [NUM_LEAVES-1:0]  summary_reg, summary_next;
    logic [MODE_W-1:0]      mode_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [IDX_BITS-1:0]    j2_reg, j2_next;
    rsp_t                   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_reg;

    logic                   req_accept;
    logic                   load_out;
    logic                   wr_en;
    logic [LEAF_W-1:0]      wr_data;
    logic                   rd_en;
    logic [IDX_BITS-1:0]    rd_addr;
    logic [LEAF_W-1:0]      rd_data;

    logic [IDX_BITS-1:0]    j;
    logic [LEAF_BITS-1:0]   x;
    logic [LEAF_W-1:0]      leaf;
    logic [LEAF_W-1:0]      sum_w;
    logic [LEAF_W-1:0]      bit_oh;
    logic [LEAF_W-1:0]      w_next;
    logic [LEAF_W-1:0]      w_prev;
    logic [LEAF_W-1:0]      s_next;
    logic [LEAF_W-1:0]      s_prev;
    logic [LEAF_BITS-1:0]   s_next_idx;
    logic [LEAF_BITS-1:0]   s_prev_idx;

    iset_leaf_ram #(
        .DEPTH(NUM_LEAVES),
        .WIDTH(LEAF_W)
    ) u_leaf_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (j),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && (state_reg == ST_IDLE);
    assign load_out   = (state_reg == ST_DONE) && (!out_valid_reg || !rsp_stall);

    assign j      = key_reg[KEY_BITS-1:LEAF_BITS];
    assign x      = key_reg[LEAF_BITS-1:0];
    // A leaf with a clear summary bit holds no members, whatever the memory says.
    assign leaf   = summary_reg[j] ? rd_data : '0;
    assign sum_w  = LEAF_W'(summary_reg);
    assign bit_oh = LEAF_W'(1) << x;

    assign w_next = leaf & ({LEAF_W{1'b1}} << x);
    assign w_prev = leaf & ({LEAF_W{1'b1}} >> (LEAF_BITS'(LEAF_W - 1) - x));
    assign s_next = sum_w & (({LEAF_W{1'b1}} << j) << 1);
    assign s_prev = sum_w & ~({LEAF_W{1'b1}} << j);

    assign s_next_idx = low_index(s_next);
    assign s_prev_idx = high_index(s_prev);

    always_comb
    begin
        state_next   = state_reg;
        summary_next = summary_reg;
        j2_next      = j2_reg;
        res_next     = res_reg;
        wr_en        = 1'b0;
        wr_data      = leaf;
        rd_en        = 1'b0;
        rd_addr      = req.key[KEY_BITS-1:LEAF_BITS];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF:
            begin
                res_next   = '0;
                state_next = ST_DONE;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        wr_en           = 1'b1;
                        wr_data         = leaf | bit_oh;
                        summary_next[j] = 1'b1;
                    end
                    MODE_ERASE:
                    begin
                        wr_en           = 1'b1;
                        wr_data         = leaf & ~bit_oh;
                        summary_next[j] = |(leaf & ~bit_oh);
                    end
                    MODE_NEXT:
                    begin
                        if (|w_next)
                        begin
                            res_next.value = KEY_W'({j, low_index(w_next)});
                            res_next.found = 1'b1;
                        end
                        else if (|s_next)
                        begin
                            j2_next    = s_next_idx[IDX_BITS-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = s_next_idx[IDX_BITS-1:0];
                            state_next = ST_SCAN2;
                        end
                    end
                    MODE_PREV:
                    begin
                        if (|w_prev)
                        begin
                            res_next.value = KEY_W'({j, high_index(w_prev)});
                            res_next.found = 1'b1;
                        end
                        else if (|s_prev)
                        begin
                            j2_next    = s_prev_idx[IDX_BITS-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = s_prev_idx[IDX_BITS-1:0];
                            state_next = ST_SCAN2;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        summary_next = '0;
                    end
                    default:
                    begin
                        summary_next = summary_reg;
                    end
                endcase
                res_next.set_empty = ~|summary_next;
            end
            ST_SCAN2:
            begin
                // The chosen leaf has its summary bit set, so the memory word is live.
                res_next.found     = 1'b1;
                res_next.set_empty = ~|summary_reg;
                if (mode_reg == MODE_NEXT)
                begin
                    res_next.value = KEY_W'({j2_reg, low_index(rd_data)});
                end
                else
                begin
                    res_next.value = KEY_W'({j2_reg, high_index(rd_data)});
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            summary_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            summary_reg   <= summary_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            mode_reg <= req.mode;
            key_reg  <= req.key[KEY_BITS-1:0];
        end
        j2_reg  <= j2_next;
        res_reg <= res_next;
        if (load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: rtl/core/iset_leaf_ram.sv
// Simple dual-port leaf word memory with a registered read port.
module iset_leaf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/iset_checker.sv
// Port-level checker for the integer set core and its bind statement.
module iset_checker
    import iset_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    logic [1:0] pend_reg, pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = req_valid && !req_stall;
    assign out_xfer = rsp_valid && !rsp_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A response never appears without a request that has not yet been answered.
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response offered with no pending request");

    // At most one request in work and one response waiting.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests outstanding");

    // A failed search or a non-search reports value zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.value == '0)
        else $error("nonzero value without a found member");

    // A search that finds a member cannot report an empty set.
    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> !rsp.set_empty)
        else $error("member found in an empty set");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

endmodule

bind integer_set_successor_predecessor_core iset_checker u_iset_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
